// ----- rtl/spti_pkg.sv -----
`default_nettype none
package spti_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int NUM_TYPES   = 8;
    localparam int ROW_W       = $clog2(TABLE_DEPTH);
    localparam int TYPE_W      = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int STOP_DEPTH  = TABLE_DEPTH * NUM_TYPES;
    localparam int STOP_AW     = $clog2(STOP_DEPTH);
    localparam int CNT_W       = 10;
    localparam int CNT_MIN     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int ITER_W      = 5;
    localparam logic [ITER_W-1:0] ITER_LAST = '1;

    localparam logic [31:0]    RST_CUTOFF = 32'd65536;
    localparam logic [CNT_W-1:0] RST_COUNT = CNT_W'(2);
    localparam logic [7:0]     RST_MIN_NB = 8'd5;
    localparam logic [31:0]    RST_TSTEP  = 32'd66;
    localparam logic [62:0]    LOSS_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF = 3'd0,
        CFG_COUNT  = 3'd1,
        CFG_MIN_NB = 3'd2,
        CFG_TSTEP  = 3'd3,
        CFG_REGION = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ATOM = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        RD_E0, RD_LAST, RD_MID, RD_LO, RD_HI
    } t_rd_sel;

    typedef enum logic [2:0] {
        MS_INTERP, MS_VX, MS_VY, MS_VZ, MS_POWER, MS_TS_HI, MS_TS_LO
    } t_mul_sel;

    typedef struct packed {
        logic     capture;
        logic     tbl_we;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     cap_e0;
        logic     cap_last;
        logic     srch_init;
        logic     srch_upd;
        logic     cap_lo;
        logic     cap_hi;
        logic     prep;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_load;
        logic     sq_load;
        logic     sq_acc;
        logic     iter_init;
        logic     iter_step;
        logic     se_calc;
        logic     plo_save;
        logic     thi_save;
        logic     term_calc;
        logic     acc_upd;
        logic     out_load;
        logic     out_applied;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
        logic qualify;
        logic mid_is_lo;
        logic iter_last;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- rtl/spti_ram.sv -----
`default_nettype none
module spti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/spti_ctrl.sv -----
`default_nettype none
module spti_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire spti_pkg::t_dp_stat i_stat,
    output logic                    o_busy,
    output spti_pkg::t_dp_cmd       o_cmd
);
    import spti_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE   = 23'(1) << 0,
        S_DECODE = 23'(1) << 1,
        S_CHK1   = 23'(1) << 2,
        S_CHK2   = 23'(1) << 3,
        S_QUAL   = 23'(1) << 4,
        S_SMID   = 23'(1) << 5,
        S_SCMP   = 23'(1) << 6,
        S_BRK0   = 23'(1) << 7,
        S_BRK1   = 23'(1) << 8,
        S_BRK2   = 23'(1) << 9,
        S_PREP   = 23'(1) << 10,
        S_MI     = 23'(1) << 11,
        S_MVX    = 23'(1) << 12,
        S_MVY    = 23'(1) << 13,
        S_MVZ    = 23'(1) << 14,
        S_IINIT  = 23'(1) << 15,
        S_ITER   = 23'(1) << 16,
        S_SE     = 23'(1) << 17,
        S_MP     = 23'(1) << 18,
        S_MH     = 23'(1) << 19,
        S_ML     = 23'(1) << 20,
        S_TERM   = 23'(1) << 21,
        S_FIN    = 23'(1) << 22
    } t_state;

    t_state r_state, n_state;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_load) begin
                    o_cmd.tbl_we   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_E0;
                    n_state      = S_CHK1;
                end
            end
            S_CHK1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LAST;
                o_cmd.cap_e0 = 1'b1;
                n_state      = S_CHK2;
            end
            S_CHK2: begin
                o_cmd.cap_last = 1'b1;
                n_state        = S_QUAL;
            end
            S_QUAL: begin
                if (i_stat.qualify) begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SMID;
                end else begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SMID: begin
                if (i_stat.mid_is_lo) begin
                    n_state = S_BRK0;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_MID;
                    n_state      = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.srch_upd = 1'b1;
                n_state        = S_SMID;
            end
            S_BRK0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LO;
                n_state      = S_BRK1;
            end
            S_BRK1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HI;
                o_cmd.cap_lo = 1'b1;
                n_state      = S_BRK2;
            end
            S_BRK2: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MI;
            end
            S_MI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_INTERP;
                n_state       = S_MVX;
            end
            S_MVX: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_VX;
                o_cmd.div_load = 1'b1;
                n_state        = S_MVY;
            end
            S_MVY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_VY;
                o_cmd.sq_load = 1'b1;
                n_state       = S_MVZ;
            end
            S_MVZ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_VZ;
                o_cmd.sq_acc  = 1'b1;
                n_state       = S_IINIT;
            end
            S_IINIT: begin
                o_cmd.iter_init = 1'b1;
                n_state         = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter_step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = S_SE;
                end
            end
            S_SE: begin
                o_cmd.se_calc = 1'b1;
                n_state       = S_MP;
            end
            S_MP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_POWER;
                n_state       = S_MH;
            end
            S_MH: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_TS_HI;
                o_cmd.plo_save = 1'b1;
                n_state        = S_ML;
            end
            S_ML: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_TS_LO;
                o_cmd.thi_save = 1'b1;
                n_state        = S_TERM;
            end
            S_TERM: begin
                o_cmd.term_calc = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                o_cmd.acc_upd     = 1'b1;
                o_cmd.out_load    = 1'b1;
                o_cmd.out_applied = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/spti_dp.sv -----
`default_nettype none
module spti_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire spti_pkg::t_dp_cmd                 i_cmd,
    output spti_pkg::t_dp_stat                     o_stat,
    input  wire logic                              i_cfg_we,
    input  wire logic [spti_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data,
    input  wire logic                              i_opcode,
    input  wire logic [8:0]                        i_table_index,
    input  wire logic [31:0]                       i_table_value,
    input  wire logic [3:0]                        i_type_index,
    input  wire logic [31:0]                       i_kinetic_energy,
    input  wire logic [7:0]                        i_neighbor_count,
    input  wire logic                              i_in_group,
    input  wire logic                              i_in_region,
    input  wire logic signed [31:0]                i_velocity_x,
    input  wire logic signed [31:0]                i_velocity_y,
    input  wire logic signed [31:0]                i_velocity_z,
    output logic                                   o_done,
    output logic                                   o_applied,
    output logic [31:0]                            o_stopping_power,
    output logic signed [31:0]                     o_delta_force_x,
    output logic signed [31:0]                     o_delta_force_y,
    output logic signed [31:0]                     o_delta_force_z,
    output logic [62:0]                            o_energy_loss_total
);
    import spti_pkg::*;

    function automatic logic [31:0] f_abs(input logic [31:0] v);
        f_abs = v[31] ? (~v) + 32'd1 : v;
    endfunction

    // -sign(v)*se, saturated to the signed range
    function automatic logic [31:0] f_delta(input logic [31:0] v, input logic [31:0] se);
        if (v == '0 || se == '0) begin
            f_delta = '0;
        end else if (v[31]) begin
            f_delta = se[31] ? 32'h7FFF_FFFF : se;
        end else begin
            f_delta = se[31] ? 32'h8000_0000 : (~se) + 32'd1;
        end
    endfunction

    // configuration
    logic [31:0]      r_cfg_cutoff;
    logic [CNT_W-1:0] r_cfg_count;
    logic [7:0]       r_cfg_min_nb;
    logic [31:0]      r_cfg_tstep;
    logic             r_cfg_region;

    // captured item
    logic        r_op;
    logic [8:0]  r_row;
    logic [31:0] r_val;
    logic [3:0]  r_typ;
    logic [31:0] r_ke;
    logic [7:0]  r_nb;
    logic        r_grp;
    logic        r_reg;
    logic [31:0] r_vx, r_vy, r_vz;

    // search and bracket
    logic [31:0]      r_e0, r_elast, r_elo, r_ehi, r_slo, r_shi;
    logic [ROW_W-1:0] r_lo, r_hi;
    logic [31:0]      r_span, r_off, r_diff;
    logic             r_flat, r_up;

    // shared multiplier and iterative units
    logic [63:0]       r_prod;
    logic [31:0]       r_rem, r_dlo;
    logic [63:0]       r_sq, r_rad;
    logic [33:0]       r_srem;
    logic [31:0]       r_root;
    logic [ITER_W-1:0] r_iter;
    logic [31:0]       r_se, r_plo;
    logic [63:0]       r_thi;
    logic [62:0]       r_term, r_acc;

    logic        r_done, r_applied;
    logic [31:0] r_sp, r_dfx, r_dfy, r_dfz;

    logic [ROW_W:0]     w_eff;
    logic [ROW_W-1:0]   w_last, w_mid, w_raddr;
    logic               w_row_ok, w_typ_ok, w_qual;
    logic [TYPE_W-1:0]  w_tm1;
    logic [STOP_AW-1:0] w_base;
    logic [31:0]        w_e_rd, w_s_rd;
    logic [31:0]        w_span, w_off0, w_off, w_diff;
    logic               w_flat, w_up;
    logic [31:0]        w_ma, w_mb;
    logic [32:0]        w_dt, w_dsub;
    logic               w_dge;
    logic [35:0]        w_st, w_trial, w_ssub;
    logic               w_sge;
    logic               w_hi_ovf;
    logic [63:0]        w_tsum, w_asum;

    always_comb begin
        if (r_cfg_count < CNT_W'(CNT_MIN)) begin
            w_eff = (ROW_W+1)'(CNT_MIN);
        end else if (32'(r_cfg_count) > TABLE_DEPTH) begin
            w_eff = (ROW_W+1)'(TABLE_DEPTH);
        end else begin
            w_eff = (ROW_W+1)'(r_cfg_count);
        end
    end
    assign w_last = ROW_W'(w_eff - (ROW_W+1)'(1));
    assign w_mid  = r_lo + ((r_hi - r_lo) >> 1);

    assign w_row_ok = (32'(r_row) < TABLE_DEPTH);
    assign w_typ_ok = (r_typ != 4'd0) && (32'(r_typ) <= NUM_TYPES);
    assign w_tm1    = TYPE_W'(r_typ - 4'd1);
    assign w_base   = STOP_AW'(w_tm1) * STOP_AW'(TABLE_DEPTH);

    assign w_qual = r_grp && (!r_cfg_region || r_reg) && (r_nb > r_cfg_min_nb) && w_typ_ok
                    && (r_ke >= r_cfg_cutoff) && (r_ke >= r_e0) && (r_ke <= r_elast);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_E0:   w_raddr = '0;
            RD_LAST: w_raddr = w_last;
            RD_MID:  w_raddr = w_mid;
            RD_LO:   w_raddr = r_lo;
            RD_HI:   w_raddr = r_hi;
            default: w_raddr = '0;
        endcase
    end

    spti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_energy (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tbl_we && w_row_ok && (r_typ == 4'd0)),
        .i_waddr (ROW_W'(r_row)),
        .i_wdata (r_val),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_e_rd)
    );

    spti_ram #(.WIDTH(32), .DEPTH(STOP_DEPTH)) u_stop (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tbl_we && w_row_ok && w_typ_ok),
        .i_waddr (w_base + STOP_AW'(ROW_W'(r_row))),
        .i_wdata (r_val),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_base + STOP_AW'(w_raddr)),
        .o_rdata (w_s_rd)
    );

    // bracket preparation
    assign w_flat = (r_ehi <= r_elo);
    assign w_span = r_ehi - r_elo;
    assign w_off0 = (r_ke > r_elo) ? r_ke - r_elo : '0;
    assign w_off  = (w_off0 > w_span) ? w_span : w_off0;
    assign w_up   = (r_shi >= r_slo);
    assign w_diff = w_up ? r_shi - r_slo : r_slo - r_shi;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_INTERP: begin w_ma = r_diff;          w_mb = r_off;       end
            MS_VX:     begin w_ma = f_abs(r_vx);     w_mb = f_abs(r_vx); end
            MS_VY:     begin w_ma = f_abs(r_vy);     w_mb = f_abs(r_vy); end
            MS_VZ:     begin w_ma = f_abs(r_vz);     w_mb = f_abs(r_vz); end
            MS_POWER:  begin w_ma = r_se;            w_mb = r_root;      end
            MS_TS_HI:  begin w_ma = r_prod[63:32];   w_mb = r_cfg_tstep; end
            MS_TS_LO:  begin w_ma = r_plo;           w_mb = r_cfg_tstep; end
            default:   begin w_ma = '0;              w_mb = '0;          end
        endcase
    end

    // restoring divide, quotient shifts into r_dlo
    assign w_dt   = {r_rem, r_dlo[31]};
    assign w_dsub = w_dt - {1'b0, r_span};
    assign w_dge  = (w_dt >= {1'b0, r_span});

    // digit-by-digit floor square root
    assign w_st    = {r_srem, r_rad[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ssub  = w_st - w_trial;
    assign w_sge   = (w_st >= w_trial);

    assign w_hi_ovf = |r_thi[63:48];
    assign w_tsum   = {1'b0, r_thi[47:0], 15'b0} + 64'(r_prod[63:17]);
    assign w_asum   = {1'b0, r_acc} + {1'b0, r_term};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cutoff <= RST_CUTOFF;
            r_cfg_count  <= RST_COUNT;
            r_cfg_min_nb <= RST_MIN_NB;
            r_cfg_tstep  <= RST_TSTEP;
            r_cfg_region <= 1'b0;
            r_acc        <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CUTOFF: r_cfg_cutoff <= i_cfg_data;
                    CFG_COUNT:  r_cfg_count  <= i_cfg_data[CNT_W-1:0];
                    CFG_MIN_NB: r_cfg_min_nb <= i_cfg_data[7:0];
                    CFG_TSTEP:  r_cfg_tstep  <= i_cfg_data;
                    CFG_REGION: r_cfg_region <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.acc_upd) begin
                r_acc <= w_asum[63] ? LOSS_MAX : w_asum[62:0];
            end
            r_done <= i_cmd.out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_row <= i_table_index;
            r_val <= i_table_value;
            r_typ <= i_type_index;
            r_ke  <= i_kinetic_energy;
            r_nb  <= i_neighbor_count;
            r_grp <= i_in_group;
            r_reg <= i_in_region;
            r_vx  <= i_velocity_x;
            r_vy  <= i_velocity_y;
            r_vz  <= i_velocity_z;
        end
        if (i_cmd.cap_e0) begin
            r_e0 <= w_e_rd;
        end
        if (i_cmd.cap_last) begin
            r_elast <= w_e_rd;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= w_last;
        end else if (i_cmd.srch_upd) begin
            if (w_e_rd < r_ke) begin
                r_lo <= w_mid;
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.cap_lo) begin
            r_elo <= w_e_rd;
            r_slo <= w_s_rd;
        end
        if (i_cmd.cap_hi) begin
            r_ehi <= w_e_rd;
            r_shi <= w_s_rd;
        end
        if (i_cmd.prep) begin
            r_span <= w_span;
            r_off  <= w_off;
            r_diff <= w_diff;
            r_flat <= w_flat;
            r_up   <= w_up;
        end
        if (i_cmd.mul_en) begin
            r_prod <= {32'b0, w_ma} * {32'b0, w_mb};
        end
        if (i_cmd.div_load) begin
            r_rem <= r_prod[63:32];
            r_dlo <= r_prod[31:0];
        end else if (i_cmd.iter_step) begin
            r_rem <= w_dge ? w_dsub[31:0] : w_dt[31:0];
            r_dlo <= {r_dlo[30:0], w_dge};
        end
        if (i_cmd.sq_load) begin
            r_sq <= r_prod;
        end else if (i_cmd.sq_acc) begin
            r_sq <= r_sq + r_prod;
        end
        if (i_cmd.iter_init) begin
            r_rad  <= r_sq + r_prod;
            r_srem <= '0;
            r_root <= '0;
            r_iter <= '0;
        end else if (i_cmd.iter_step) begin
            r_rad  <= r_rad << 2;
            r_srem <= w_sge ? w_ssub[33:0] : w_st[33:0];
            r_root <= {r_root[30:0], w_sge};
            r_iter <= r_iter + ITER_W'(1);
        end
        if (i_cmd.se_calc) begin
            if (r_flat) begin
                r_se <= r_slo;
            end else if (r_up) begin
                r_se <= r_slo + r_dlo;
            end else begin
                r_se <= r_slo - r_dlo;
            end
        end
        if (i_cmd.plo_save) begin
            r_plo <= r_prod[31:0];
        end
        if (i_cmd.thi_save) begin
            r_thi <= r_prod;
        end
        if (i_cmd.term_calc) begin
            r_term <= (w_hi_ovf || w_tsum > {1'b0, LOSS_MAX}) ? LOSS_MAX : w_tsum[62:0];
        end
        if (i_cmd.out_load) begin
            r_applied <= i_cmd.out_applied;
            r_sp      <= i_cmd.out_applied ? r_se : '0;
            r_dfx     <= i_cmd.out_applied ? f_delta(r_vx, r_se) : '0;
            r_dfy     <= i_cmd.out_applied ? f_delta(r_vy, r_se) : '0;
            r_dfz     <= i_cmd.out_applied ? f_delta(r_vz, r_se) : '0;
        end
    end

    assign o_stat.is_load   = (t_op'(r_op) == OP_LOAD);
    assign o_stat.qualify   = w_qual;
    assign o_stat.mid_is_lo = (w_mid == r_lo);
    assign o_stat.iter_last = (r_iter == ITER_LAST);

    assign o_done              = r_done;
    assign o_applied           = r_applied;
    assign o_stopping_power    = r_sp;
    assign o_delta_force_x     = r_dfx;
    assign o_delta_force_y     = r_dfy;
    assign o_delta_force_z     = r_dfz;
    assign o_energy_loss_total = r_acc;
endmodule
`default_nettype wire

// ----- rtl/stopping_power_table_interp.sv -----
// One item at a time: a new item is accepted only in the idle state. A qualifying atom
// runs a binary search of at most 9 probes. Most of the work goes into the 32-step shared
// divide/square-root iteration and into the search, each probe of which reads the registered
// energy RAM and then compares. Synchronous active-low reset clears control and the loss
// total and sets the configuration to its defaults; the table RAMs are not cleared.
// Results cannot be stalled: o_done lasts one cycle.
`default_nettype none
module stopping_power_table_interp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic                           i_cfg_we,
    input  wire logic [spti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data,
    input  wire logic                           i_opcode,
    input  wire logic [8:0]                     i_table_index,
    input  wire logic [31:0]                    i_table_value,
    input  wire logic [3:0]                     i_type_index,
    input  wire logic [31:0]                    i_kinetic_energy,
    input  wire logic [7:0]                     i_neighbor_count,
    input  wire logic                           i_in_group,
    input  wire logic                           i_in_region,
    input  wire logic signed [31:0]             i_velocity_x,
    input  wire logic signed [31:0]             i_velocity_y,
    input  wire logic signed [31:0]             i_velocity_z,
    output logic                                o_done,
    output logic                                o_applied,
    output logic [31:0]                         o_stopping_power,
    output logic signed [31:0]                  o_delta_force_x,
    output logic signed [31:0]                  o_delta_force_y,
    output logic signed [31:0]                  o_delta_force_z,
    output logic [62:0]                         o_energy_loss_total
);
    import spti_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    spti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd)
    );

    spti_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_opcode            (i_opcode),
        .i_table_index       (i_table_index),
        .i_table_value       (i_table_value),
        .i_type_index        (i_type_index),
        .i_kinetic_energy    (i_kinetic_energy),
        .i_neighbor_count    (i_neighbor_count),
        .i_in_group          (i_in_group),
        .i_in_region         (i_in_region),
        .i_velocity_x        (i_velocity_x),
        .i_velocity_y        (i_velocity_y),
        .i_velocity_z        (i_velocity_z),
        .o_done              (o_done),
        .o_applied           (o_applied),
        .o_stopping_power    (o_stopping_power),
        .o_delta_force_x     (o_delta_force_x),
        .o_delta_force_y     (o_delta_force_y),
        .o_delta_force_z     (o_delta_force_z),
        .o_energy_loss_total (o_energy_loss_total)
    );
endmodule
`default_nettype wire
